FILE: src/ihw_pkg.sv
// Shared types, microcode table and helpers for the Intel hex record writer.
// Depends on nothing; all files but ihw_if take names from here by scope.
package ihw_pkg;

	localparam int PC_W = 5;

	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_ORG    = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
	localparam logic [PC_W-1:0] PC_ERR   = 5'd1;
	localparam logic [PC_W-1:0] PC_FLUSH = 5'd2;
	localparam logic [PC_W-1:0] PC_DATA  = 5'd11;
	localparam logic [PC_W-1:0] PC_END   = 5'd16;

	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_LF    = 8'h0a;

	typedef enum logic [3:0] {
		CS_CONST,
		CS_CNT_HI,
		CS_CNT_LO,
		CS_ADDR3,
		CS_ADDR2,
		CS_ADDR1,
		CS_ADDR0,
		CS_DAT_HI,
		CS_DAT_LO,
		CS_SUM_HI,
		CS_SUM_LO,
		CS_ERR
	} char_sel_t;

	typedef enum logic [1:0] {
		LAST_NONE,
		LAST_ALWAYS,
		LAST_IF_NO_END
	} last_sel_t;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_MORE,
		JC_END
	} jump_t;

	typedef struct packed {
		logic            emit;
		char_sel_t       sel;
		logic [7:0]      chr;
		last_sel_t       last;
		jump_t           jmp;
		logic [PC_W-1:0] target;
		logic            idx_inc;
		logic            flush_done;
	} ucw_t;

	// sequencer to datapath
	typedef struct packed {
		logic       fire;
		char_sel_t  sel;
		logic [7:0] chr;
		logic       last;
		logic       idx_inc;
		logic       flush_done;
	} dp_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic past_end;
		logic count_zero;
		logic will_fill;
		logic more;
	} dp_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else begin
			r = 8'h57 + {4'd0, d};
		end
		return r;
	endfunction

	function automatic ucw_t uc(input logic e, input char_sel_t s, input logic [7:0] c,
			input last_sel_t l, input jump_t j, input logic [PC_W-1:0] t,
			input logic ii, input logic fd);
		ucw_t w;
		w.emit       = e;
		w.sel        = s;
		w.chr        = c;
		w.last       = l;
		w.jmp        = j;
		w.target     = t;
		w.idx_inc    = ii;
		w.flush_done = fd;
		return w;
	endfunction

	// Control store: one word per step.
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		case (pc)
			5'd1:  w = uc(1'b1, CS_ERR,    8'h00,    LAST_ALWAYS, JC_ALWAYS, PC_IDLE, 1'b0, 1'b0);
			5'd2:  w = uc(1'b1, CS_CONST,  CH_COLON, LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd3:  w = uc(1'b1, CS_CNT_HI, 8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd4:  w = uc(1'b1, CS_CNT_LO, 8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd5:  w = uc(1'b1, CS_ADDR3,  8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd6:  w = uc(1'b1, CS_ADDR2,  8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd7:  w = uc(1'b1, CS_ADDR1,  8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd8:  w = uc(1'b1, CS_ADDR0,  8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd9:  w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd10: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd11: w = uc(1'b1, CS_DAT_HI, 8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd12: w = uc(1'b1, CS_DAT_LO, 8'h00,    LAST_NONE,   JC_MORE,   PC_DATA, 1'b1, 1'b0);
			5'd13: w = uc(1'b1, CS_SUM_HI, 8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd14: w = uc(1'b1, CS_SUM_LO, 8'h00,    LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd15: w = uc(1'b1, CS_CONST,  CH_LF,    LAST_IF_NO_END, JC_END, PC_IDLE, 1'b0, 1'b1);
			// end record
			5'd16: w = uc(1'b1, CS_CONST,  CH_COLON, LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd17: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd18: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd19: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd20: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd21: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd22: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd23: w = uc(1'b1, CS_CONST,  CH_ZERO,  LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd24: w = uc(1'b1, CS_CONST,  CH_ONE,   LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd25: w = uc(1'b1, CS_CONST,  CH_F,     LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd26: w = uc(1'b1, CS_CONST,  CH_F,     LAST_NONE,   JC_NEXT,   PC_IDLE, 1'b0, 1'b0);
			5'd27: w = uc(1'b1, CS_CONST,  CH_LF,    LAST_ALWAYS, JC_ALWAYS, PC_IDLE, 1'b0, 1'b0);
			default: w = uc(1'b0, CS_CONST, 8'h00,   LAST_NONE,   JC_ALWAYS, PC_IDLE, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

FILE: src/ihw_if.sv
// Valid/ready channel interfaces: command words in, text characters out.
// Standalone; no package use.
interface ihw_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic [16:0] new_address;

	modport source (output valid, output operation, output data_byte, output new_address,
		input ready);
	modport sink (input valid, input operation, input data_byte, input new_address,
		output ready);
endinterface

interface ihw_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;
	logic       addr_error;

	modport source (output valid, output out_char, output last_char, output addr_error,
		input ready);
	modport sink (input valid, input out_char, input last_char, input addr_error,
		output ready);
endinterface

FILE: src/ihw_datapath.sv
// Row buffer, address state, checksum and output character register.
// Depends on ihw_pkg for control and status structs and the hex helper.
module ihw_datapath #(
	parameter int RECORD_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        operation,
	input  logic [7:0]        data_byte,
	input  logic [16:0]       new_address,
	input  ihw_pkg::dp_ctrl_t ctrl,
	output ihw_pkg::dp_stat_t stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        out_char,
	output logic              last_char,
	output logic              addr_error
);

	localparam int CNT_W = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

	logic [7:0]       row_bytes_q [RECORD_BYTES];
	logic [CNT_W-1:0] row_count_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      row_address_q;
	logic [15:0]      current_address_q;
	logic             past_end_q;
	logic [7:0]       row_sum_q;

	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             last_q;
	logic             err_q;

	logic             take_byte;
	logic [7:0]       rd_byte;
	logic [7:0]       cnt_byte;
	logic [7:0]       check;
	logic [7:0]       ch;

	assign take_byte = accept && (operation == ihw_pkg::OP_DATA) && !past_end_q;
	assign rd_byte   = row_bytes_q[idx_q];
	assign cnt_byte  = 8'(row_count_q);
	assign check     = 8'd0 - (cnt_byte + row_address_q[15:8] + row_address_q[7:0] + row_sum_q);

	assign stat.past_end   = past_end_q;
	assign stat.count_zero = (row_count_q == '0);
	assign stat.will_fill  = ((row_count_q + CNT_W'(1)) == CNT_W'(RECORD_BYTES));
	assign stat.more       = ((CNT_W'(idx_q) + CNT_W'(1)) != row_count_q);

	always_ff @(posedge clk) begin
		if (take_byte) begin
			row_bytes_q[row_count_q[IDX_W-1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q       <= '0;
			idx_q             <= '0;
			row_address_q     <= '0;
			current_address_q <= '0;
			past_end_q        <= 1'b0;
			row_sum_q         <= '0;
		end else begin
			if (take_byte) begin
				row_count_q       <= row_count_q + CNT_W'(1);
				row_sum_q         <= row_sum_q + data_byte;
				current_address_q <= current_address_q + 16'd1;
				if (current_address_q == 16'hffff) begin
					past_end_q <= 1'b1;
				end
			end
			if (accept && operation == ihw_pkg::OP_ORG) begin
				past_end_q        <= new_address[16];
				current_address_q <= new_address[15:0];
				if (row_count_q == '0) begin
					row_address_q <= new_address[15:0];
				end
			end
			if (accept && operation == ihw_pkg::OP_FINISH && row_count_q == '0) begin
				row_address_q <= current_address_q;
			end
			if (ctrl.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			// close the row once its line feed is out
			if (ctrl.flush_done) begin
				row_count_q   <= '0;
				row_sum_q     <= '0;
				idx_q         <= '0;
				row_address_q <= current_address_q;
			end
		end
	end

	always_comb begin
		case (ctrl.sel)
			ihw_pkg::CS_CONST:  ch = ctrl.chr;
			ihw_pkg::CS_CNT_HI: ch = ihw_pkg::hex_char(cnt_byte[7:4]);
			ihw_pkg::CS_CNT_LO: ch = ihw_pkg::hex_char(cnt_byte[3:0]);
			ihw_pkg::CS_ADDR3:  ch = ihw_pkg::hex_char(row_address_q[15:12]);
			ihw_pkg::CS_ADDR2:  ch = ihw_pkg::hex_char(row_address_q[11:8]);
			ihw_pkg::CS_ADDR1:  ch = ihw_pkg::hex_char(row_address_q[7:4]);
			ihw_pkg::CS_ADDR0:  ch = ihw_pkg::hex_char(row_address_q[3:0]);
			ihw_pkg::CS_DAT_HI: ch = ihw_pkg::hex_char(rd_byte[7:4]);
			ihw_pkg::CS_DAT_LO: ch = ihw_pkg::hex_char(rd_byte[3:0]);
			ihw_pkg::CS_SUM_HI: ch = ihw_pkg::hex_char(check[7:4]);
			ihw_pkg::CS_SUM_LO: ch = ihw_pkg::hex_char(check[3:0]);
			default:            ch = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			out_char_q <= ch;
			last_q     <= ctrl.last;
			err_q      <= (ctrl.sel == ihw_pkg::CS_ERR);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign last_char  = last_q;
	assign addr_error = err_q;

endmodule

FILE: src/ihw_sequencer.sv
// Step counter over the microcode table, with dispatch on each command word.
// Depends on ihw_pkg for the control store and the control/status structs.
module ihw_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [1:0]        operation,
	input  ihw_pkg::dp_stat_t stat,
	input  logic              out_free,
	output logic              accept,
	output ihw_pkg::dp_ctrl_t ctrl
);

	logic [ihw_pkg::PC_W-1:0] pc_q;
	logic [ihw_pkg::PC_W-1:0] pc_next;
	logic [ihw_pkg::PC_W-1:0] entry;
	logic                     end_q;
	logic                     end_next;
	logic                     busy;
	logic                     adv;
	ihw_pkg::ucw_t            cw;

	assign cw        = ihw_pkg::ucode(pc_q);
	assign busy      = (pc_q != ihw_pkg::PC_IDLE);
	assign cmd_ready = !busy;
	assign accept    = cmd_valid && cmd_ready;
	// hold a step while the output register is occupied and not being taken
	assign adv       = busy && (!cw.emit || out_free);

	always_comb begin
		entry    = ihw_pkg::PC_IDLE;
		end_next = 1'b0;
		case (operation)
			ihw_pkg::OP_DATA: begin
				if (stat.past_end) begin
					entry = ihw_pkg::PC_ERR;
				end else if (stat.will_fill) begin
					entry = ihw_pkg::PC_FLUSH;
				end
			end
			ihw_pkg::OP_ORG: begin
				if (!stat.count_zero) begin
					entry = ihw_pkg::PC_FLUSH;
				end
			end
			ihw_pkg::OP_FINISH: begin
				end_next = 1'b1;
				entry    = stat.count_zero ? ihw_pkg::PC_END : ihw_pkg::PC_FLUSH;
			end
			default: entry = ihw_pkg::PC_IDLE;
		endcase
	end

	always_comb begin
		pc_next = pc_q;
		if (!busy) begin
			if (accept) begin
				pc_next = entry;
			end
		end else if (adv) begin
			case (cw.jmp)
				ihw_pkg::JC_NEXT:   pc_next = pc_q + ihw_pkg::PC_W'(1);
				ihw_pkg::JC_ALWAYS: pc_next = cw.target;
				ihw_pkg::JC_MORE:   pc_next = stat.more ? cw.target : pc_q + ihw_pkg::PC_W'(1);
				ihw_pkg::JC_END:    pc_next = end_q ? pc_q + ihw_pkg::PC_W'(1) : cw.target;
				default:            pc_next = ihw_pkg::PC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= ihw_pkg::PC_IDLE;
			end_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (accept) begin
				end_q <= end_next;
			end
		end
	end

	always_comb begin
		ctrl.fire       = adv && cw.emit;
		ctrl.sel        = cw.sel;
		ctrl.chr        = cw.chr;
		ctrl.idx_inc    = adv && cw.idx_inc;
		ctrl.flush_done = adv && cw.flush_done;
		case (cw.last)
			ihw_pkg::LAST_ALWAYS:    ctrl.last = 1'b1;
			ihw_pkg::LAST_IF_NO_END: ctrl.last = !end_q;
			default:                 ctrl.last = 1'b0;
		endcase
	end

endmodule

FILE: src/intel_hex_record_writer_core.sv
// Intel hex record writer: top level joining sequencer and datapath.
// Depends on ihw_pkg, ihw_if, ihw_sequencer and ihw_datapath.
//
// cmd carries one command word per handshake: a data byte, an address change
// or finish. text returns the hex text one character per word, last_char
// marking the final character a command caused; a data byte past FFFF gives
// one error word instead.
// A data byte that does not fill the row gives nothing. A flushed record
// gives 12 + 2*n characters at one per cycle unless the receiver stalls
// (44 for a full row of 16); finish adds the 12-character end record. The
// step counter of the microcode sequencer sets this pace: one control word
// per character. The step counter and then the output register lie between
// an accepted command and its first character. A new command is taken once
// the last character of the previous one has been loaded into the output
// register. Reset empties the row, zeroes the addresses and clears the
// output valid flag. When the receiver stalls, the output register holds
// its word and the sequencer holds its step until the word is taken.
module intel_hex_record_writer_core #(
	parameter int RECORD_BYTES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	ihw_cmd_if.sink         cmd,
	ihw_text_if.source      text
);

	ihw_pkg::dp_ctrl_t ctrl;
	ihw_pkg::dp_stat_t stat;
	logic              accept;
	logic              out_valid;

	assign text.valid = out_valid;

	ihw_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.operation (cmd.operation),
		.stat      (stat),
		.out_free  (!out_valid || text.ready),
		.accept    (accept),
		.ctrl      (ctrl)
	);

	ihw_datapath #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (cmd.operation),
		.data_byte   (cmd.data_byte),
		.new_address (cmd.new_address),
		.ctrl        (ctrl),
		.stat        (stat),
		.out_ready   (text.ready),
		.out_valid   (out_valid),
		.out_char    (text.out_char),
		.last_char   (text.last_char),
		.addr_error  (text.addr_error)
	);

endmodule

FILE: src/ihw_checker.sv
// Port-level checks for the Intel hex record writer, bound to the top level.
// Depends on intel_hex_record_writer_core, the ihw_if interfaces and ihw_pkg.
module ihw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_operation,
	input logic       text_valid,
	input logic       text_ready,
	input logic [7:0] text_char,
	input logic       text_last,
	input logic       text_err
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_char)
			&& $stable(text_last) && $stable(text_err))
		else $error("text word changed while stalled");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_err |-> text_char == 8'h00 && text_last)
		else $error("error word not a single zero character");

	// finish always produces text, so the block is busy next cycle
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_operation == ihw_pkg::OP_FINISH |=> !cmd_ready)
		else $error("finish accepted without starting output");

	// an unknown operation is dropped
	a_unknown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_operation == ihw_pkg::OP_NONE |=> cmd_ready)
		else $error("unknown operation started a sequence");

endmodule

bind intel_hex_record_writer_core ihw_checker u_ihw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_operation (cmd.operation),
	.text_valid    (text.valid),
	.text_ready    (text.ready),
	.text_char     (text.out_char),
	.text_last     (text.last_char),
	.text_err      (text.addr_error)
);

FILE: verif/intel_hex_record_writer_core_test.sv
// Self-checking bench for intel_hex_record_writer_core: command words in, hex text out.
// Depends on ihw_pkg, ihw_cmd_if and ihw_text_if; checks against its own record encoder.
`timescale 1ns / 1ps

module intel_hex_record_writer_core_test;

	localparam int          ROW_MAX     = 16;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 80;
	localparam int unsigned LIMIT       = 400000;
	localparam int          PHASE_WORDS = 28;
	localparam string       END_RECORD  = ":00000001ff\n";

	typedef enum int {PH_FLOW, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [16:0] addr;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} text_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cmd_valid = 1'b0;
	logic [1:0]  cmd_op = ihw_pkg::OP_DATA;
	logic [7:0]  cmd_data = 8'h00;
	logic [16:0] cmd_addr = 17'h0;
	logic        text_ready = 1'b0;

	ihw_cmd_if  cmd_ch ();
	ihw_text_if text_ch ();

	assign cmd_ch.valid       = cmd_valid;
	assign cmd_ch.operation   = cmd_op;
	assign cmd_ch.data_byte   = cmd_data;
	assign cmd_ch.new_address = cmd_addr;
	assign text_ch.ready      = text_ready;

	intel_hex_record_writer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.text   (text_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	phase_t      phase = PH_FLOW;
	cmd_word_t   pending[$];
	cmd_word_t   in_flight;
	text_word_t  hex_text[$];
	int          errors = 0;
	int          words_taken = 0;
	int          chars_checked = 0;
	int          records_out = 0;
	int          refused = 0;
	int          end_records = 0;
	logic        long_hold_armed = 1'b0;
	logic        hold_used = 1'b0;
	int          hold_cnt = 0;
	int unsigned cycle_count = 0;

	// encoder state
	logic [7:0]  row_buf [ROW_MAX];
	logic [4:0]  row_fill = 5'd0;
	logic [15:0] row_base = 16'h0;
	logic [15:0] load_addr = 16'h0;
	logic        beyond_top = 1'b0;

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int send_idle_pct(input phase_t p);
		case (p)
			PH_SEND_IDLE: return 68;
			PH_BOTH:      return 27;
			default:      return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input phase_t p);
		case (p)
			PH_RECV_STALL: return 68;
			PH_BOTH:       return 27;
			default:       return 0;
		endcase
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] d);
		return (d < 4'd10) ? 8'h30 + 8'(d) : 8'h61 + 8'(d) - 8'd10;
	endfunction

	task automatic put_char(input logic [7:0] ch, input logic err);
		text_word_t w;
		w.ch   = ch;
		w.last = 1'b0;
		w.err  = err;
		hex_text.push_back(w);
	endtask

	task automatic put_hex(input logic [7:0] b);
		put_char(nibble_char(b[7:4]), 1'b0);
		put_char(nibble_char(b[3:0]), 1'b0);
	endtask

	task automatic put_record();
		logic [7:0] sum;
		if (row_fill != 5'd0) begin
			put_char(ihw_pkg::CH_COLON, 1'b0);
			put_hex({3'b0, row_fill});
			put_hex(row_base[15:8]);
			put_hex(row_base[7:0]);
			put_hex(8'h00);
			sum = {3'b0, row_fill} + row_base[15:8] + row_base[7:0];
			for (int i = 0; i < int'(row_fill); i++) begin
				put_hex(row_buf[i]);
				sum = sum + row_buf[i];
			end
			put_hex(~sum + 8'd1);
			put_char(ihw_pkg::CH_LF, 1'b0);
			records_out++;
		end
		row_fill = 5'd0;
		row_base = load_addr;
	endtask

	// work out the text one accepted command word causes
	task automatic encode_word(input cmd_word_t w);
		int first;
		first = hex_text.size();
		case (w.op)
			ihw_pkg::OP_DATA: begin
				if (beyond_top) begin
					put_char(8'h00, 1'b1);
					refused++;
				end else begin
					if (row_fill < ROW_MAX) row_buf[row_fill[3:0]] = w.data;
					row_fill = row_fill + 5'd1;
					load_addr = load_addr + 16'd1;
					if (load_addr == 16'h0) beyond_top = 1'b1;
					if (row_fill >= ROW_MAX) put_record();
				end
			end
			ihw_pkg::OP_ORG: begin
				beyond_top = w.addr[16];
				load_addr = w.addr[15:0];
				put_record();
			end
			ihw_pkg::OP_FINISH: begin
				put_record();
				for (int i = 0; i < END_RECORD.len(); i++) put_char(END_RECORD[i], 1'b0);
				end_records++;
			end
			default: ;
		endcase
		if (hex_text.size() > first) hex_text[hex_text.size() - 1].last = 1'b1;
	endtask

	// unused fields get random content so every bit toggles
	task automatic queue_word(input logic [1:0] op, input logic [7:0] data,
			input logic [16:0] addr);
		cmd_word_t w;
		w.op   = op;
		w.data = (op == ihw_pkg::OP_DATA) ? data : 8'($urandom);
		w.addr = (op == ihw_pkg::OP_ORG) ? addr : 17'($urandom);
		pending.push_back(w);
	endtask

	task automatic queue_run(input int n, inout int counted);
		for (int i = 0; i < n; i++) queue_word(ihw_pkg::OP_DATA, 8'($urandom), 17'h0);
		counted += n;
	endtask

	task automatic queue_burst(output int counted);
		int r;
		int n;
		logic [1:0] op;
		counted = 0;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			queue_word(ihw_pkg::OP_ORG, 8'h0, {1'b0, 16'($urandom)});
			counted++;
			n = roll(30) ? ROW_MAX : $urandom_range(1, 20);
			if (roll(10)) n = 2 * ROW_MAX + $urandom_range(0, 3);
			queue_run(n, counted);
			if (roll(25)) begin
				queue_word(ihw_pkg::OP_FINISH, 8'h0, 17'h0);
				counted++;
			end
		end else if (r < 70) begin
			// run up to or across FFFF, with refused bytes past it, then back down
			queue_word(ihw_pkg::OP_ORG, 8'h0, 17'h0FFF0 + 17'($urandom_range(0, 15)));
			counted++;
			queue_run($urandom_range(1, 24), counted);
			queue_word(ihw_pkg::OP_ORG, 8'h0, {1'b0, 16'($urandom_range(0, 16'h7fff))});
			counted++;
		end else if (r < 80) begin
			queue_word(ihw_pkg::OP_ORG, 8'h0, {1'b1, 16'($urandom)});
			counted++;
			queue_run($urandom_range(1, 3), counted);
			queue_word(ihw_pkg::OP_ORG, 8'h0, {1'b0, 16'($urandom)});
			counted++;
		end else if (r < 90) begin
			queue_run($urandom_range(0, 5), counted);
			queue_word(ihw_pkg::OP_FINISH, 8'h0, 17'h0);
			counted++;
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				op = 2'($urandom_range(0, 3));
				queue_word(op, 8'($urandom), 17'($urandom));
				if (op != ihw_pkg::OP_NONE) counted++;
			end
		end
	endtask

	task automatic report_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 30)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// driver: present one word, advance on handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ch.ready) begin
				encode_word(in_flight);
				words_taken++;
			end
			if (!cmd_valid || cmd_ch.ready) begin
				if (pending.size() != 0 && !roll(send_idle_pct(phase))) begin
					in_flight = pending.pop_front();
					cmd_valid <= 1'b1;
					cmd_op    <= in_flight.op;
					cmd_data  <= in_flight.data;
					cmd_addr  <= in_flight.addr;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (long_hold_armed && !hold_used) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// monitor: check each taken character against the oldest expectation
	always @(posedge clk) begin
		text_word_t want;
		if (arst_n) begin
			if (text_ch.valid && text_ready) begin
				chars_checked++;
				if (hex_text.size() == 0) begin
					errors++;
					if (errors <= 30)
						$display("%0t: unexpected word, expected none, actual char %0h last %b err %b",
							$time, text_ch.out_char, text_ch.last_char, text_ch.addr_error);
				end else begin
					want = hex_text.pop_front();
					report_field("out_char", want.ch, text_ch.out_char);
					report_field("last_char", want.last, text_ch.last_char);
					report_field("addr_error", want.err, text_ch.addr_error);
				end
			end
			text_ready <= (hold_cnt == 0) && !roll(recv_stall_pct(phase));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("intel_hex_record_writer_core test failed");
			$finish;
		end
	end

	initial begin
		int got;
		int n;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, finish, wrap, refused bytes, empty flushes
		queue_word(ihw_pkg::OP_DATA, 8'h00, 17'h1ffff);
		queue_word(ihw_pkg::OP_DATA, 8'hff, 17'h00000);
		queue_word(ihw_pkg::OP_DATA, 8'h5a, 17'h1ffff);
		queue_word(ihw_pkg::OP_FINISH, 8'hff, 17'h1ffff);
		queue_word(ihw_pkg::OP_ORG, 8'h00, 17'h1ffff);
		queue_word(ihw_pkg::OP_DATA, 8'hff, 17'h0);
		queue_word(ihw_pkg::OP_DATA, 8'h00, 17'h0);
		queue_word(ihw_pkg::OP_ORG, 8'h00, 17'h0fffe);
		queue_word(ihw_pkg::OP_DATA, 8'hff, 17'h0);
		queue_word(ihw_pkg::OP_DATA, 8'h80, 17'h0);
		queue_word(ihw_pkg::OP_DATA, 8'h01, 17'h0);
		queue_word(ihw_pkg::OP_ORG, 8'h00, 17'h10000);
		queue_word(ihw_pkg::OP_DATA, 8'h7f, 17'h0);
		queue_word(ihw_pkg::OP_NONE, 8'hff, 17'h1ffff);
		queue_word(ihw_pkg::OP_FINISH, 8'h00, 17'h0);
		queue_word(ihw_pkg::OP_ORG, 8'h00, 17'h00000);
		queue_word(ihw_pkg::OP_ORG, 8'h00, 17'h0ffff);
		queue_word(ihw_pkg::OP_DATA, 8'haa, 17'h0);
		queue_word(ihw_pkg::OP_DATA, 8'h55, 17'h0);
		queue_word(ihw_pkg::OP_FINISH, 8'h00, 17'h0);

		for (int p = PH_FLOW; p <= PH_HOLD; p++) begin
			@(negedge clk);
			phase = phase_t'(p);
			if (phase == PH_HOLD) long_hold_armed = 1'b1;
			n = 0;
			while (n < PHASE_WORDS) begin
				queue_burst(got);
				n += got;
			end
			// wait until the sender is done and the text has drained
			while (pending.size() != 0 || cmd_valid) @(negedge clk);
			while (hex_text.size() != 0) @(negedge clk);
		end
		phase = PH_FLOW;
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);

		if (hex_text.size() != 0) begin
			errors++;
			$display("%0t: %0d expected characters never arrived, next %0h", $time,
				hex_text.size(), hex_text[0].ch);
		end
		$display("Sent %0d command words: %0d records, %0d end records, %0d refused bytes.",
			words_taken, records_out, end_records, refused);
		$display("Checked %0d characters over free flow, idle, stall and long hold-off phases.",
			chars_checked);
		if (errors == 0) begin
			$display("intel_hex_record_writer_core test passed");
		end else begin
			$display("intel_hex_record_writer_core test failed");
		end
		$finish;
	end

endmodule
